// ===== rtl/fdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fdc_pkg: shared types and constants of the frame deframer
// Status codes, header layout, the queued transaction type and the CRC-32 step.
// -----------------------------------------------------------------------------
package fdc_pkg;

    localparam int BUFFER_BYTES = 4096;
    localparam int HEADER_BYTES = 20;
    localparam logic [11:0] BUF_LIMIT = 12'(BUFFER_BYTES - HEADER_BYTES);
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    localparam logic [4:0] HDR_MAGIC_END = 5'd3;
    localparam logic [4:0] HDR_VERSION   = 5'd4;
    localparam logic [4:0] HDR_TYPE      = 5'd5;
    localparam logic [4:0] HDR_FLAGS_END = 5'd7;
    localparam logic [4:0] HDR_SEQ_END   = 5'd11;
    localparam logic [4:0] HDR_LEN_END   = 5'd15;
    localparam logic [4:0] HDR_LAST      = 5'(HEADER_BYTES - 1);

    localparam logic [1:0] CFG_MAGIC   = 2'd0;
    localparam logic [1:0] CFG_VERSION = 2'd1;
    localparam logic [1:0] CFG_MAX     = 2'd2;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_MAGIC   = 3'd1,
        ST_VERSION = 3'd2,
        ST_LONG    = 3'd3,
        ST_CRC     = 3'd4
    } status_t;

    // What the front part hands to the back part for each result.
    // A payload byte carries its CRC verdict inputs; the back part folds the CRC.
    typedef struct packed {
        logic [7:0]  data;
        logic        byte_valid;
        logic        first;       // first payload byte: CRC restarts
        logic        frame_end;
        logic        crc_check;   // frame_end on a payload byte: compare CRC
        status_t     status;
        logic [31:0] exp_crc;
        logic [7:0]  frame_type;
        logic [15:0] frame_flags;
        logic [31:0] sequence_res;
        logic [11:0] payload_length;
    } fdc_item_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/fdc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fdc_front: header parser and classifier
// Parses header bytes, checks them and emits one transaction per result.
// -----------------------------------------------------------------------------
module fdc_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [31:0]       expected_magic,
    input  wire logic [7:0]        expected_version,
    input  wire logic [11:0]       max_payload,
    output fdc_pkg::fdc_item_t     item,
    output logic                   item_valid
);

    logic        in_payload_reg, in_payload_next;
    logic        first_reg, first_next;
    logic [4:0]  count_reg, count_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] magic_reg, magic_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] flags_reg, flags_next;
    logic [31:0] seq_reg, seq_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] crc_reg, crc_next;
    logic [11:0] left_reg, left_next;
    logic [11:0] limit;
    logic        fits;
    logic [11:0] left_dec;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_payload_reg <= 1'b0;
            first_reg      <= 1'b0;
            count_reg      <= '0;
            shift_reg      <= '0;
            magic_reg      <= '0;
            version_reg    <= '0;
            type_reg       <= '0;
            flags_reg      <= '0;
            seq_reg        <= '0;
            len_reg        <= '0;
            crc_reg        <= '0;
            left_reg       <= '0;
        end else begin
            in_payload_reg <= in_payload_next;
            first_reg      <= first_next;
            count_reg      <= count_next;
            shift_reg      <= shift_next;
            magic_reg      <= magic_next;
            version_reg    <= version_next;
            type_reg       <= type_next;
            flags_reg      <= flags_next;
            seq_reg        <= seq_next;
            len_reg        <= len_next;
            crc_reg        <= crc_next;
            left_reg       <= left_next;
        end
    end

    assign limit    = (max_payload < fdc_pkg::BUF_LIMIT) ? max_payload : fdc_pkg::BUF_LIMIT;
    assign left_dec = left_reg - 12'd1;

    always_comb begin
        in_payload_next = in_payload_reg;
        first_next      = first_reg;
        count_next      = count_reg;
        shift_next      = shift_reg;
        magic_next      = magic_reg;
        version_next    = version_reg;
        type_next       = type_reg;
        flags_next      = flags_reg;
        seq_next        = seq_reg;
        len_next        = len_reg;
        crc_next        = crc_reg;
        left_next       = left_reg;
        item_valid      = 1'b0;
        item            = '0;
        fits            = 1'b0;

        if (in_valid) begin
            if (in_payload_reg) begin
                left_next  = left_dec;
                first_next = 1'b0;
                item_valid = 1'b1;
                item.data       = rx_byte;
                item.byte_valid = 1'b1;
                item.first      = first_reg;
                if (left_dec == 12'd0) begin
                    in_payload_next = 1'b0;
                    count_next      = '0;
                    item.frame_end  = 1'b1;
                    item.crc_check  = 1'b1;
                end
            end else begin
                shift_next = {shift_reg[23:0], rx_byte};
                case (count_reg)
                    fdc_pkg::HDR_MAGIC_END: magic_next   = shift_next;
                    fdc_pkg::HDR_VERSION:   version_next = rx_byte;
                    fdc_pkg::HDR_TYPE:      type_next    = rx_byte;
                    fdc_pkg::HDR_FLAGS_END: flags_next   = shift_next[15:0];
                    fdc_pkg::HDR_SEQ_END:   seq_next     = shift_next;
                    fdc_pkg::HDR_LEN_END:   len_next     = shift_next;
                    fdc_pkg::HDR_LAST:      crc_next     = shift_next;
                    default: ;
                endcase
                if (count_reg < fdc_pkg::HDR_LAST) begin
                    count_next = count_reg + 5'd1;
                end else begin
                    count_next = '0;
                    fits = (len_reg <= {20'd0, limit});
                    if (magic_reg != expected_magic) begin
                        item_valid  = 1'b1;
                        item.status = fdc_pkg::ST_MAGIC;
                    end else if (version_reg != expected_version) begin
                        item_valid  = 1'b1;
                        item.status = fdc_pkg::ST_VERSION;
                    end else if (!fits) begin
                        item_valid  = 1'b1;
                        item.status = fdc_pkg::ST_LONG;
                    end else if (len_reg == 32'd0) begin
                        item_valid  = 1'b1;
                        item.status = (crc_next == 32'd0) ? fdc_pkg::ST_OK : fdc_pkg::ST_CRC;
                    end else begin
                        in_payload_next = 1'b1;
                        first_next      = 1'b1;
                        left_next       = len_reg[11:0];
                    end
                    item.frame_end = 1'b1;
                end
            end
        end
        item.exp_crc      = crc_next;
        item.frame_type   = type_next;
        item.frame_flags  = flags_next;
        item.sequence_res = seq_next;
        item.payload_length = (len_next <= {20'd0, limit}) ? len_next[11:0] : 12'd0;
    end

endmodule
`default_nettype wire

// ===== rtl/fdc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fdc_queue: four-entry queue between the front and the back part
// Flip-flop storage, with a reserve that tracks the back part's own slot.
// -----------------------------------------------------------------------------
module fdc_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire fdc_pkg::fdc_item_t wr_item,
    input  wire logic              rd_en,
    output fdc_pkg::fdc_item_t     rd_item,
    output logic                   not_empty,
    output logic                   almost_full
);

    fdc_pkg::fdc_item_t mem_reg [4];
    logic [1:0] wp_reg, wp_next;
    logic [1:0] rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wp_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_comb begin
        wp_next  = wr_en ? wp_reg + 2'd1 : wp_reg;
        rp_next  = rd_en ? rp_reg + 2'd1 : rp_reg;
        cnt_next = cnt_reg + {2'd0, wr_en} - {2'd0, rd_en};
    end

    assign rd_item     = mem_reg[rp_reg];
    assign not_empty   = (cnt_reg != 3'd0);
    assign almost_full = (cnt_reg >= 3'd3);

    assert property (@(posedge clk) disable iff (!rst_n) !(wr_en && cnt_reg == 3'd4))
        else $error("fdc_queue: write into a full queue");
    assert property (@(posedge clk) disable iff (!rst_n) !(rd_en && cnt_reg == 3'd0))
        else $error("fdc_queue: read from an empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 3'd4)
        else $error("fdc_queue: count out of range");

endmodule
`default_nettype wire

// ===== rtl/fdc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fdc_back: CRC accumulator and result register
// Folds each payload byte into the CRC and presents the finished result.
// -----------------------------------------------------------------------------
module fdc_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_not_empty,
    input  wire fdc_pkg::fdc_item_t q_item,
    output logic                   q_rd,
    input  wire logic              pop,
    output logic                   empty,
    output fdc_pkg::fdc_item_t     res_item
);

    logic [31:0]         crc_reg, crc_next;
    logic                full_reg;
    fdc_pkg::fdc_item_t  res_reg, res_next;
    logic [31:0]         crc_base;

    assign q_rd  = q_not_empty && (!full_reg || pop);
    assign empty = !full_reg;
    assign res_item = res_reg;

    always_comb begin
        crc_base = q_item.first ? 32'hFFFF_FFFF : crc_reg;
        crc_next = crc_reg;
        res_next = q_item;
        if (q_item.byte_valid) begin
            crc_next = fdc_pkg::crc_byte(crc_base, q_item.data);
            if (q_item.crc_check) begin
                res_next.status = ((~crc_next) == q_item.exp_crc) ?
                                  fdc_pkg::ST_OK : fdc_pkg::ST_CRC;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            full_reg <= 1'b0;
            crc_reg  <= 32'hFFFF_FFFF;
        end else begin
            if (q_rd) begin
                full_reg <= 1'b1;
                crc_reg  <= crc_next;
            end else if (pop) begin
                full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (q_rd) begin
            res_reg <= res_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) (full_reg && !pop) |=> $stable(res_reg))
        else $error("fdc_back: held result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (full_reg && !res_reg.frame_end) |-> res_reg.status == fdc_pkg::ST_OK)
        else $error("fdc_back: error status on a mid-frame result");
    assert property (@(posedge clk) disable iff (!rst_n)
        (full_reg && !res_reg.byte_valid) |-> res_reg.frame_end)
        else $error("fdc_back: header result that does not end a frame");

endmodule
`default_nettype wire

// ===== rtl/frame_deframer_crc32_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// frame_deframer_crc32_top: length-prefixed frame deframer with CRC-32 check
// Parses a 20-byte header, passes payload bytes on and reports the frame verdict.
// -----------------------------------------------------------------------------
// The block takes one received byte per transaction and sustains one byte per
// clock cycle while full is low. A byte passes through the header parser
// (front part), a four-entry queue and the CRC unit with its result register
// (back part). The parser writes the queue at the edge that accepts the byte,
// and the back part loads its result register from the queue. Header bytes
// give no result except the last one, which ends the frame on a bad magic, bad
// version, over-long length or an empty payload. Payload bytes come out one
// result each, and the last carries the CRC verdict; a consumer discards the
// payload of a frame whose final status is not zero. After an error, header
// parsing restarts at the very next byte. full rises while the queue has at
// most one free slot, so input is only held off when the consumer stalls.
// Configuration registers: 0 magic, 1 version, 2 payload cap (12 bits).
// -----------------------------------------------------------------------------
module frame_deframer_crc32_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       payload_byte,
    output logic             byte_valid,
    output logic             frame_end,
    output logic [2:0]       status,
    output logic [7:0]       frame_type,
    output logic [15:0]      frame_flags,
    output logic [31:0]      sequence_res,
    output logic [11:0]      payload_length,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic [31:0] magic_reg;
    logic [7:0]  version_reg;
    logic [11:0] max_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            magic_reg   <= '0;
            version_reg <= '0;
            max_reg     <= 12'd4076;
        end else if (cfg_we) begin
            case (cfg_index)
                fdc_pkg::CFG_MAGIC:   magic_reg   <= cfg_data;
                fdc_pkg::CFG_VERSION: version_reg <= cfg_data[7:0];
                fdc_pkg::CFG_MAX:     max_reg     <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    fdc_pkg::fdc_item_t f_item, q_item, r_item;
    logic f_valid, q_ne, q_af, q_rd, accept;

    assign accept = push && !full;
    assign full   = q_af;

    fdc_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(accept), .rx_byte(rx_byte),
        .expected_magic(magic_reg), .expected_version(version_reg),
        .max_payload(max_reg), .item(f_item), .item_valid(f_valid)
    );

    fdc_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(f_valid), .wr_item(f_item),
        .rd_en(q_rd), .rd_item(q_item), .not_empty(q_ne), .almost_full(q_af)
    );

    fdc_back u_back (
        .clk(clk), .rst_n(rst_n), .q_not_empty(q_ne), .q_item(q_item),
        .q_rd(q_rd), .pop(pop), .empty(empty), .res_item(r_item)
    );

    assign payload_byte   = r_item.data;
    assign byte_valid     = r_item.byte_valid;
    assign frame_end      = r_item.frame_end;
    assign status         = r_item.status;
    assign frame_type     = r_item.frame_type;
    assign frame_flags    = r_item.frame_flags;
    assign sequence_res   = r_item.sequence_res;
    assign payload_length = r_item.payload_length;

endmodule
`default_nettype wire
